FILE: hw/rtl/tjq_pkg.sv
// shared constants, types and codes of the timed job queue
package tjq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int TIME_BITS   = 40;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_BITS-1:0] RECENT_SECS = TIME_BITS'(61);
    localparam logic [TIME_BITS-1:0] STALE_SECS  = TIME_BITS'(59);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef logic [2:0] status_t;

    localparam status_t ST_INSERTED   = 3'd0;
    localparam status_t ST_RECENT     = 3'd1;
    localparam status_t ST_STALE      = 3'd2;
    localparam status_t ST_FULL       = 3'd3;
    localparam status_t ST_DISPATCHED = 3'd4;
    localparam status_t ST_NOT_DUE    = 3'd5;
    localparam status_t ST_EMPTY      = 3'd6;

    typedef struct packed {
        logic                 command;
        logic [15:0]          job_id;
        logic [15:0]          run_id;
        logic [TIME_BITS-1:0] run_time;
        logic [TIME_BITS-1:0] now_time;
        logic [TIME_BITS-1:0] last_run_time;
        logic [7:0]           run_priority;
        logic [7:0]           job_priority;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic [15:0]          out_job_id;
        logic [15:0]          out_run_id;
        logic [TIME_BITS-1:0] out_run_time;
        logic [7:0]           out_priority;
    } res_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] run_time;
        logic [7:0]           priority_val;
        logic [15:0]          job_id;
        logic [15:0]          run_id;
    } entry_t;

    // requests from the sequencer to the entry ring, indices are queue positions
    typedef struct packed {
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_idx;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_idx;
        entry_t              wr_entry;
        logic                pop;
    } ring_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_RECENT,
        S_CHK_STALE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT,
        S_WRITE,
        S_POP,
        S_RESP
    } state_t;

endpackage

FILE: hw/rtl/tjq_cmd_if.sv
// command channel carrying one insert or pop word
interface tjq_cmd_if
    import tjq_pkg::*;
();
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tjq_res_if.sv
// result channel carrying one status word
interface tjq_res_if
    import tjq_pkg::*;
();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/timed_job_queue_core.sv
// timed job queue: sorted pending-job store with insert and due-pop commands
//
// Pending jobs are held sorted by run time, then by effective priority
// (smaller first), equal entries in arrival order. Each command word gives
// exactly one status word. An insert is first checked against the last-run
// time (within 61 s: dropped recent) and the current time (more than 59 s
// past: dropped stale), then against a full queue. A pop hands back the
// head once its run time is not after now_time, else reports not due with
// the head fields, or empty. The block takes one command at a time; a
// command waits in the response stage while the result register stays
// full. An accepted insert first searches for its position and, when it
// goes in front of a queued entry, moves the entries from there on up to
// open a gap. The entry ring has a single read and a single write port:
// the position search reads one entry per cycle and the move that opens
// the gap moves one entry per cycle. All time compares share one
// subtractor. The result register lets the next command be accepted
// while a status word still waits to be taken.
module timed_job_queue_core
    import tjq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    tjq_cmd_if.sink          cmd,
    tjq_res_if.source        res
);

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    // scan index during the search, gap cursor during the move
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] pos_reg, pos_next;
    cmd_t                item_reg, item_next;
    logic [7:0]          prio_reg, prio_next;
    res_t                pend_reg, pend_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    ring_req_t           ring_req;
    entry_t              rd_entry;

    // shared subtractor for every time compare
    logic [TIME_BITS-1:0] op_a, op_b;
    logic [TIME_BITS:0]   sub;
    logic                 borrow;
    logic [TIME_BITS-1:0] diff;
    logic                 hit;
    logic [CNT_BITS-1:0]  cursor;

    tjq_entry_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .rd_data (rd_entry)
    );

    always_comb
    begin
        case (state_reg)
            S_CHK_RECENT:
            begin
                op_a = item_reg.run_time;
                op_b = item_reg.last_run_time;
            end
            S_CHK_STALE:
            begin
                op_a = item_reg.now_time;
                op_b = item_reg.run_time;
            end
            S_SCAN:
            begin
                op_a = item_reg.run_time;
                op_b = rd_entry.run_time;
            end
            S_POP:
            begin
                op_a = item_reg.now_time;
                op_b = rd_entry.run_time;
            end
            default:
            begin
                op_a = item_reg.run_time;
                op_b = item_reg.last_run_time;
            end
        endcase
    end

    assign sub    = {1'b0, op_a} - {1'b0, op_b};
    assign borrow = sub[TIME_BITS];
    assign diff   = sub[TIME_BITS-1:0];
    // queued entry runs later, or same time with a larger priority value
    assign hit    = borrow || (diff == '0 && rd_entry.priority_val > prio_reg);
    assign cursor = idx_reg - CNT_BITS'(1);

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        item_next      = item_reg;
        prio_next      = prio_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ring_req       = '0;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // head read issued early for a pop
                ring_req.rd_en  = 1'b1;
                ring_req.rd_idx = '0;
                if (cmd.valid)
                begin
                    item_next = cmd.data;
                    prio_next = (cmd.data.run_priority != 8'd0) ? cmd.data.run_priority
                                                                : cmd.data.job_priority;
                    if (cmd.data.command == CMD_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            pend_next        = '0;
                            pend_next.status = ST_EMPTY;
                            state_next       = S_RESP;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    else
                    begin
                        state_next = S_CHK_RECENT;
                    end
                end
            end

            S_CHK_RECENT:
            begin
                if (borrow || diff < RECENT_SECS)
                begin
                    pend_next        = '0;
                    pend_next.status = ST_RECENT;
                    state_next       = S_RESP;
                end
                else
                begin
                    state_next = S_CHK_STALE;
                end
            end

            S_CHK_STALE:
            begin
                pend_next = '0;
                if (!borrow && diff > STALE_SECS)
                begin
                    pend_next.status = ST_STALE;
                    state_next       = S_RESP;
                end
                else if (count_reg == CNT_BITS'(QUEUE_DEPTH))
                begin
                    pend_next.status = ST_FULL;
                    state_next       = S_RESP;
                end
                else if (count_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = S_WRITE;
                end
                else
                begin
                    ring_req.rd_en  = 1'b1;
                    ring_req.rd_idx = '0;
                    idx_next        = '0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SHIFT_RD;
                end
                else if (idx_reg + CNT_BITS'(1) == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next        = idx_reg + CNT_BITS'(1);
                    ring_req.rd_en  = 1'b1;
                    ring_req.rd_idx = idx_next[IDX_BITS-1:0];
                end
            end

            S_SHIFT_RD:
            begin
                // gap cursor is above the insert position here
                ring_req.rd_en  = 1'b1;
                ring_req.rd_idx = cursor[IDX_BITS-1:0];
                state_next      = S_SHIFT;
            end

            S_SHIFT:
            begin
                ring_req.wr_en    = 1'b1;
                ring_req.wr_idx   = idx_reg[IDX_BITS-1:0];
                ring_req.wr_entry = rd_entry;
                idx_next          = cursor;
                if (cursor == pos_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    ring_req.rd_en  = 1'b1;
                    ring_req.rd_idx = IDX_BITS'(cursor - CNT_BITS'(1));
                end
            end

            S_WRITE:
            begin
                ring_req.wr_en                 = 1'b1;
                ring_req.wr_idx                = pos_reg[IDX_BITS-1:0];
                ring_req.wr_entry.run_time     = item_reg.run_time;
                ring_req.wr_entry.priority_val = prio_reg;
                ring_req.wr_entry.job_id       = item_reg.job_id;
                ring_req.wr_entry.run_id       = item_reg.run_id;
                count_next                     = count_reg + CNT_BITS'(1);
                pend_next                      = '0;
                pend_next.status               = ST_INSERTED;
                state_next                     = S_RESP;
            end

            S_POP:
            begin
                pend_next.out_job_id   = rd_entry.job_id;
                pend_next.out_run_id   = rd_entry.run_id;
                pend_next.out_run_time = rd_entry.run_time;
                pend_next.out_priority = rd_entry.priority_val;
                if (borrow)
                begin
                    // head not yet due, stays queued
                    pend_next.status = ST_NOT_DUE;
                end
                else
                begin
                    pend_next.status = ST_DISPATCHED;
                    ring_req.pop     = 1'b1;
                    count_next       = count_reg - CNT_BITS'(1);
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and cursors, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        item_reg <= item_next;
        prio_reg <= prio_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // one command in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command taken while another is in work");

    // count only moves on an insert write or a dispatch
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            ($past(state_reg) == S_WRITE || $past(state_reg) == S_POP))
        else $error("entry count changed outside insert or dispatch");

    // a new status word only comes from the response stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result raised outside response stage");

    // no ring write during a dispatch
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_req.pop && ring_req.wr_en))
        else $error("ring write and pop in one cycle");

endmodule

FILE: hw/rtl/tjq_entry_ring.sv
// entry store as a ring buffer: queue position to slot mapping, head advance on pop
module tjq_entry_ring
    import tjq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ring_req_t req,
    output entry_t    rd_data
);

    entry_t              mem [QUEUE_DEPTH];
    logic [IDX_BITS-1:0] head_reg;
    logic [IDX_BITS-1:0] head_next;
    logic [IDX_BITS-1:0] rd_slot;
    logic [IDX_BITS-1:0] wr_slot;

    function automatic logic [IDX_BITS-1:0] to_slot(input logic [IDX_BITS-1:0] head,
                                                     input logic [IDX_BITS-1:0] idx);
        logic [IDX_BITS:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (IDX_BITS+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IDX_BITS+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_BITS-1:0];
    endfunction

    assign rd_slot   = to_slot(head_reg, req.rd_idx);
    assign wr_slot   = to_slot(head_reg, req.wr_idx);
    assign head_next = to_slot(head_reg, IDX_BITS'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (req.pop)
        begin
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_slot] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[rd_slot];
        end
    end

endmodule

FILE: dv/tjq_queue_checker.sv
// checker: shadow job queue, expected status words and field compare
`timescale 1ns / 1ps
module tjq_queue_checker
    import tjq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    tjq_cmd_if    cmd,
    tjq_res_if    res,
    output int    fail_count,
    output int    pending
);

    localparam int REPORT_LIMIT = 10;

    entry_t queued[$];       // shadow of the pending jobs, head first
    res_t   status_due[$];   // status words still to come, oldest first
    res_t   want;
    res_t   seen;
    string  bad_fields;
    int     fails;

    function automatic res_t predict_status(cmd_t c);
        res_t        r;
        entry_t      e;
        logic [7:0]  prio;
        int          pos;
        int          i;
        r = '0;
        if (c.command == CMD_POP) begin
            if (queued.size() == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                e = queued[0];
                r.status       = (e.run_time > c.now_time) ? ST_NOT_DUE : ST_DISPATCHED;
                r.out_job_id   = e.job_id;
                r.out_run_id   = e.run_id;
                r.out_run_time = e.run_time;
                r.out_priority = e.priority_val;
                if (r.status == ST_DISPATCHED) begin
                    void'(queued.pop_front());
                end
            end
        end
        else begin
            prio = (c.run_priority != 8'd0) ? c.run_priority : c.job_priority;
            if (c.run_time < c.last_run_time || c.run_time - c.last_run_time < RECENT_SECS) begin
                r.status = ST_RECENT;
            end
            else if (c.now_time > c.run_time && c.now_time - c.run_time > STALE_SECS) begin
                r.status = ST_STALE;
            end
            else if (queued.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                // first entry due later, or same time with a larger priority value
                pos = queued.size();
                for (i = 0; i < queued.size(); i++) begin
                    if (pos == queued.size() && (queued[i].run_time > c.run_time ||
                        (queued[i].run_time == c.run_time && queued[i].priority_val > prio))) begin
                        pos = i;
                    end
                end
                e.run_time     = c.run_time;
                e.priority_val = prio;
                e.job_id       = c.job_id;
                e.run_id       = c.run_id;
                queued.insert(pos, e);
                r.status = ST_INSERTED;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(string why, res_t exp_w, res_t got_w);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $display("%0t mismatch:%s | expected st=%0d job=%h run=%h time=%h prio=%h",
                     $realtime, why, exp_w.status, exp_w.out_job_id, exp_w.out_run_id,
                     exp_w.out_run_time, exp_w.out_priority);
            $display("    got st=%0d job=%h run=%h time=%h prio=%h",
                     got_w.status, got_w.out_job_id, got_w.out_run_id,
                     got_w.out_run_time, got_w.out_priority);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            queued.delete();
            status_due.delete();
            fails = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else begin
            // the word leaving this edge belongs to an earlier command
            if (res.valid && res.ready) begin
                seen = res.data;
                if (status_due.size() == 0) begin
                    note_mismatch(" word with none expected", '0, seen);
                end
                else begin
                    want = status_due.pop_front();
                    bad_fields = "";
                    if (seen.status !== want.status)             bad_fields = {bad_fields, " status"};
                    if (seen.out_job_id !== want.out_job_id)     bad_fields = {bad_fields, " job"};
                    if (seen.out_run_id !== want.out_run_id)     bad_fields = {bad_fields, " run"};
                    if (seen.out_run_time !== want.out_run_time) bad_fields = {bad_fields, " time"};
                    if (seen.out_priority !== want.out_priority) bad_fields = {bad_fields, " prio"};
                    if (bad_fields.len() > 0) begin
                        note_mismatch(bad_fields, want, seen);
                    end
                end
            end
            if (cmd.valid && cmd.ready) begin
                status_due.push_back(predict_status(cmd.data));
            end
            fail_count <= fails;
            pending <= status_due.size();
        end
    end

endmodule

FILE: dv/tb.sv
// testbench top: clock, reset, command stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module tb;
    import tjq_pkg::*;

    localparam int RANDOM_WORDS = 1100;
    localparam int CYCLE_LIMIT  = 800000;
    // settle time after the last expected word, so that a late stray word is caught
    localparam int SETTLE_CYCLES = 64;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   long_stall = 0;
    int   words_sent = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;
    int   kind;
    int   len;
    int   i;
    logic [TIME_BITS-1:0] t_base;

    tjq_cmd_if cmd_ch ();
    tjq_res_if res_ch ();

    timed_job_queue_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    tjq_queue_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: short random stalls, now and then a long one so that a
    // finished word sits in the result register while the next command runs
    always @(posedge clk)
    begin
        if (long_stall > 0)
        begin
            long_stall <= long_stall - 1;
            res_ch.ready <= 1'b0;
        end
        else if (stall_pct > 0 && $urandom_range(31) == 0)
        begin
            long_stall <= $urandom_range(60, 10);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    // half the priorities from a tiny range so that ties are common
    function automatic logic [7:0] rand_prio();
        return ($urandom_range(1) == 0) ? 8'($urandom_range(4)) : 8'($urandom);
    endfunction

    function automatic cmd_t insert_word(logic [15:0] job, logic [15:0] run,
                                         logic [TIME_BITS-1:0] rt, logic [TIME_BITS-1:0] now,
                                         logic [TIME_BITS-1:0] last,
                                         logic [7:0] rprio, logic [7:0] jprio);
        cmd_t w;
        w.command       = CMD_INSERT;
        w.job_id        = job;
        w.run_id        = run;
        w.run_time      = rt;
        w.now_time      = now;
        w.last_run_time = last;
        w.run_priority  = rprio;
        w.job_priority  = jprio;
        return w;
    endfunction

    // pop ignores everything but now_time, the rest is random filler
    function automatic cmd_t pop_word(logic [TIME_BITS-1:0] now);
        cmd_t w;
        w = insert_word(16'($urandom), 16'($urandom), rand_time(), now, rand_time(),
                        8'($urandom), 8'($urandom));
        w.command = CMD_POP;
        return w;
    endfunction

    // insert near the current time base; edgy picks the drop boundaries
    function automatic cmd_t job_insert(bit edgy);
        logic [TIME_BITS-1:0] rt;
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] last;
        int                   sel;
        rt   = t_base + (($urandom_range(2) == 0) ? $urandom_range(3) * 10 : $urandom_range(150));
        last = rt - 61 - $urandom_range(5000);
        now  = t_base + $urandom_range(30);
        sel  = edgy ? $urandom_range(5) : 5;
        if (sel == 0)
            last = rt - $urandom_range(70);
        else if (sel == 1)
            now = rt + $urandom_range(70, 50);
        return insert_word(16'($urandom), 16'($urandom), rt, now, last,
                           ($urandom_range(4) < 2) ? rand_prio() : 8'd0, rand_prio());
    endfunction

    function automatic cmd_t noise_word();
        cmd_t w;
        w = insert_word(16'($urandom), 16'($urandom), rand_time(), rand_time(), rand_time(),
                        8'($urandom), 8'($urandom));
        w.command = 1'($urandom);
        return w;
    endfunction

    task automatic send_word(cmd_t w);
        if ($urandom_range(99) < gap_pct)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(45, 1)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= w;
        do @(posedge clk); while (!cmd_ch.ready);
        words_sent++;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, both drop checks at their boundaries,
        // priority override, tie ordering, not due and due-at-now
        send_word(pop_word('0));
        send_word(pop_word(TIME_MAX));
        send_word(insert_word(16'h0001, 16'h0001, 0, 0, 0, 8'd0, 8'd0));        // zero gap: recent
        send_word(insert_word(16'h0002, 16'h0002, 100, 100, 40, 8'd0, 8'd5));   // 60 s: recent
        send_word(insert_word(16'h0003, 16'h0003, 100, 100, 200, 8'd0, 8'd5));  // last after run
        send_word(insert_word(16'hFFFF, 16'h0000, 1000, 1059, 939, 8'd0, 8'hFF));  // both edges ok
        send_word(insert_word(16'h0004, 16'h0004, 1000, 1060, 0, 8'd0, 8'd1));  // 60 s late: stale
        send_word(insert_word(16'h0005, 16'h0005, 1000, 0, 0, 8'd7, 8'd200));   // override wins
        send_word(insert_word(16'h0006, 16'h0006, 1000, 0, 0, 8'd0, 8'd7));     // tie, goes after
        send_word(insert_word(16'h0000, 16'hFFFF, 999, 0, 0, 8'hFF, 8'd0));     // new head
        send_word(insert_word(16'h0007, 16'h0007, TIME_MAX, TIME_MAX, 0, 8'd1, 8'd0));
        send_word(insert_word(16'h0008, 16'h0008, 2000, 0, TIME_MAX, 8'd0, 8'd0));
        send_word(insert_word(16'h0009, 16'h0009, 100, TIME_MAX, 0, 8'd0, 8'd0)); // far past
        send_word(pop_word(998));       // head at 999 not yet due
        send_word(pop_word(999));       // due exactly now
        send_word(pop_word(1000));
        send_word(pop_word(1000));
        send_word(pop_word(1000));
        send_word(pop_word(1000));      // tail at max time still waits
        send_word(pop_word(TIME_MAX));
        send_word(pop_word(TIME_MAX));  // empty again

        // random bursts; idling style changes in four quarters
        t_base = 5000;
        while (words_sent < RANDOM_WORDS)
        begin
            case (words_sent * 4 / RANDOM_WORDS)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 54;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 54;
                end
                default:
                begin
                    gap_pct = 24;
                    stall_pct = 24;
                end
            endcase
            if ($urandom_range(7) == 0)
                t_base = rand_time();
            else
                t_base = t_base + $urandom_range(120);
            kind = $urandom_range(9);
            if (kind < 2)
            begin
                // fill well past the depth so that the full case comes up
                len = $urandom_range(40, 33);
                for (i = 0; i < len; i++) send_word(job_insert(1'b0));
            end
            else if (kind == 2)
            begin
                len = $urandom_range(40, 20);
                for (i = 0; i < len; i++)
                    send_word(pop_word(($urandom_range(1) == 0) ? TIME_MAX : t_base + 1000));
            end
            else if (kind == 3)
            begin
                len = $urandom_range(8, 3);
                for (i = 0; i < len; i++) send_word(noise_word());
            end
            else
            begin
                len = $urandom_range(30, 10);
                for (i = 0; i < len; i++)
                begin
                    kind = $urandom_range(99);
                    if (kind < 55)
                        send_word(job_insert(1'b1));
                    else if (kind < 95)
                        send_word(pop_word(t_base + $urandom_range(160) - 20));
                    else
                        send_word(noise_word());
                end
            end
        end
        cmd_ch.valid <= 1'b0;

        // pending is a registered copy of the checker's count, so it lags the last acceptance
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tjq_pkg.sv
hw/rtl/tjq_cmd_if.sv
hw/rtl/tjq_res_if.sv
hw/rtl/tjq_entry_ring.sv
hw/rtl/timed_job_queue_core.sv
dv/tjq_queue_checker.sv
dv/tb.sv
